### rtl/core/spod_pkg.sv
// Shared constants, codes and types of the sonar ping onset detector.
package spod_pkg;

  localparam int CH_PORTS     = 4;
  localparam int CHANNELS     = 4;
  localparam int QUIET_WINDOW = 256;
  localparam int QCOUNT_W     = $clog2(QUIET_WINDOW + 1);

  localparam int MAG_W     = 32;
  localparam int OFFSET_W  = 24;
  localparam int HOLDOFF_W = 24;
  localparam int INDEX_W   = 32;

  localparam logic [MAG_W-1:0]     THRESH_RESET  = MAG_W'(3000);
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = HOLDOFF_W'(50000);
  localparam logic [OFFSET_W-1:0]  OFFSET_MAX    = '1;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_HOLDOFF   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic advance;  // a sample is processed this cycle
    logic active;   // detection running: lanes may latch
    logic clear;    // drop latched arrivals
  } lane_ctrl_t;

  typedef struct packed {
    logic                quiet;    // magnitude below threshold
    logic                done;     // latched before or arrives now
    logic [OFFSET_W-1:0] arrival;  // offset to report
  } lane_stat_t;

endpackage

### rtl/core/spod_lane.sv
// One hydrophone channel: threshold compares and arrival latch.
module spod_lane
  import spod_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [MAG_W-1:0]    mag,
  input  logic [MAG_W-1:0]    threshold,
  input  logic [OFFSET_W-1:0] since,
  input  lane_ctrl_t          ctrl,
  output lane_stat_t          stat
);

  logic                seen;
  logic [OFFSET_W-1:0] arr_time;
  logic                hit;

  assign hit = mag > threshold;

  assign stat.quiet   = mag < threshold;
  assign stat.done    = seen || hit;
  assign stat.arrival = seen ? arr_time : since;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (ctrl.advance) begin
      if (ctrl.clear) begin
        seen <= 1'b0;
      end else if (ctrl.active && !seen && hit) begin
        seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance && ctrl.active && !seen && hit) begin
      arr_time <= since;
    end
  end

endmodule

### rtl/core/sonar_ping_onset_detector.sv
// Top level of the sonar ping onset detector.
// Path: a sample passes the input register, then the result register that drives m_tvalid.
// Throughput: one sample per cycle; the input side stalls only while a
//   result waits in the output register and the waiting sample would emit.
// Reset (rst, synchronous): registers back to 3000 / 50000, quiet history
//   and counts cleared, window loud, detection disarmed; no clearing pass.
module sonar_ping_onset_detector
  import spod_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [MAG_W-1:0]     cfg_data,
  // sample input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [127:0]         s_tdata,  // channel_mag_0, _1, _2, _3 (32 bits each)
  // ping result
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [127:0]         m_tdata   // ping_sample_index (32), arrival_ch0..3 (24 each)
);

  // ---------------- configuration ----------------
  logic [MAG_W-1:0]     threshold;
  logic [HOLDOFF_W-1:0] holdoff_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESH_RESET;
      holdoff_len <= HOLDOFF_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD: threshold   <= cfg_data;
        REG_HOLDOFF:   holdoff_len <= cfg_data[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                   in_valid;
  logic [CH_PORTS*MAG_W-1:0] in_mag;
  logic                   advance;
  logic                   emit;
  logic                   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mag <= s_tdata;
    end
  end

  // ---------------- detector state ----------------
  logic [QUIET_WINDOW-1:0] quiet_hist;   // bit 0 newest, top bit oldest
  logic [QCOUNT_W-1:0]     quiet_count;
  logic                    loud;
  logic                    armed;
  logic [HOLDOFF_W:0]      holdoff_cnt;
  logic [OFFSET_W-1:0]     since;
  logic [INDEX_W-1:0]      sample_cnt;

  // ---------------- per-channel lanes ----------------
  lane_ctrl_t lane_ctrl;
  lane_stat_t lane_stat [CH_PORTS];

  for (genvar c = 0; c < CH_PORTS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      spod_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .mag       (in_mag[c*MAG_W +: MAG_W]),
        .threshold (threshold),
        .since     (since),
        .ctrl      (lane_ctrl),
        .stat      (lane_stat[c])
      );
    end else begin : g_unused
      // unused channel: never blocks quiet or detection, reports zero
      assign lane_stat[c] = '{quiet: 1'b1, done: 1'b1, arrival: '0};
    end
  end

  // ---------------- per-sample update ----------------
  logic                quiet;
  logic                all_done;
  logic [QCOUNT_W-1:0] quiet_count_next;
  logic                loud_next;
  logic                armed_next;
  logic [HOLDOFF_W:0]  holdoff_step;
  logic                holdoff_over;
  logic                active;
  logic [HOLDOFF_W:0]  holdoff_next;
  logic [OFFSET_W-1:0] since_next;
  logic [INDEX_W-1:0]  sample_index;

  always_comb begin
    quiet    = 1'b1;
    all_done = 1'b1;
    for (int c = 0; c < CH_PORTS; c++) begin
      quiet    = quiet && lane_stat[c].quiet;
      all_done = all_done && lane_stat[c].done;
    end

    // window count: drop the flag leaving the window, add the new one
    quiet_count_next = quiet_count - QCOUNT_W'(quiet_hist[QUIET_WINDOW-1])
                       + QCOUNT_W'(quiet);
    loud_next = quiet_count_next != QCOUNT_W'(QUIET_WINDOW);

    holdoff_step = (holdoff_cnt <= {1'b0, holdoff_len}) ? holdoff_cnt + 1'b1
                                                        : holdoff_cnt;
    holdoff_over = holdoff_step > {1'b0, holdoff_len};

    // quiet window disarms; quiet-to-loud edge arms
    armed_next = (armed && loud_next) || (!loud && loud_next);
    active     = armed_next && loud_next && holdoff_over;
    emit       = active && all_done;

    holdoff_next = emit ? '0 : holdoff_step;

    if (!loud_next || emit) begin
      since_next = '0;
    end else if (active && since != OFFSET_MAX) begin
      since_next = since + 1'b1;
    end else begin
      since_next = since;
    end

    sample_index = sample_cnt + 1'b1;

    lane_ctrl.advance = advance;
    lane_ctrl.active  = active;
    lane_ctrl.clear   = !loud_next || emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_hist  <= '0;
      quiet_count <= '0;
      loud        <= 1'b1;
      armed       <= 1'b0;
      holdoff_cnt <= {1'b0, HOLDOFF_RESET};
      since       <= '0;
      sample_cnt  <= '0;
    end else if (advance) begin
      quiet_hist  <= {quiet_hist[QUIET_WINDOW-2:0], quiet};
      quiet_count <= quiet_count_next;
      loud        <= loud_next;
      armed       <= armed_next;
      holdoff_cnt <= holdoff_next;
      since       <= since_next;
      sample_cnt  <= sample_index;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= {lane_stat[3].arrival, lane_stat[2].arrival,
                  lane_stat[1].arrival, lane_stat[0].arrival, sample_index};
    end
  end

  // ---------------- assertions ----------------
  a_count_matches_hist: assert property (@(posedge clk) disable iff (rst)
    $countones(quiet_hist) == 32'(quiet_count))
    else $error("quiet count out of step with history");

  a_quiet_disarms: assert property (@(posedge clk) disable iff (rst)
    !loud |-> !armed)
    else $error("armed while window quiet");

  a_emit_restarts_holdoff: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> holdoff_cnt == '0 && since == '0)
    else $error("holdoff or offset not restarted after ping");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sonar ping onset detector: directed plan, then random pings.
`timescale 1ns / 1ps

module tb_top;
  import spod_pkg::*;

  // Pacing. A sample passes the input register and then the result register, so a short settle
  // covers samples in flight that cause no ping.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 120;   // receiver hold-off in the pressure phase
  localparam int unsigned STALL_LIMIT   = 1000;  // cycles without any transfer
  localparam int unsigned RAND_PHASES   = 4;
  localparam int unsigned PRESSURE_PHASE = 1;

  // Input item: channel magnitudes, channel 0 in the low bits (same layout as s_tdata).
  typedef logic [CH_PORTS-1:0][MAG_W-1:0] mag_set_t;

  // Result item, laid out like m_tdata: index in the low 32 bits, then arrivals 0..3.
  typedef struct packed {
    logic [CH_PORTS-1:0][OFFSET_W-1:0] arrival;
    logic [INDEX_W-1:0]                sample_idx;
  } ping_t;

  typedef enum logic [1:0] {
    WANT_NONE,   // typed in: this row causes no ping
    WANT_PING,   // typed in: this row causes exactly the given ping
    WANT_MODEL   // ask the predictor
  } row_check_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    reg_index_t        reg_sel;
    logic [MAG_W-1:0]  value;
    mag_set_t          mag;
    int unsigned       repeats;
    row_check_t        check;
    ping_t             ping;
  } plan_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = REG_THRESHOLD;
  logic [MAG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [127:0]         s_tdata = '0;  // channel_mag_0, _1, _2, _3 (32 bits each)
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [127:0]         m_tdata;   // ping_sample_index (32), arrival_ch0..3 (24 each)

  // Travels with s_tdata so the scoreboard sees the check mode of the item it accepts.
  row_check_t item_check = WANT_MODEL;
  ping_t      item_ping  = '0;

  bit          idle_on  = 1'b1;  // random gaps on both sides
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off
  int unsigned mismatches = 0;
  ping_t       pings_due[$];     // pings predicted and not yet seen

  // Predictor state.
  logic [MAG_W-1:0]     thr_q;
  logic [HOLDOFF_W-1:0] hold_len_q;
  bit                   quiet_ring [QUIET_WINDOW];
  int unsigned          quiet_total;
  int unsigned          ring_ptr;
  bit                   loud_q;
  bit                   armed_q;
  logic [HOLDOFF_W:0]   holdoff_ctr;   // one bit wider than the register
  logic [OFFSET_W-1:0]  onset_age;
  logic [OFFSET_W-1:0]  arr_off [CH_PORTS];
  bit                   arr_hit [CH_PORTS];
  logic [INDEX_W-1:0]   sample_no;

  sonar_ping_onset_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_arrivals();
    int c;
    for (c = 0; c < CH_PORTS; c++) begin
      arr_off[c] = '0;
      arr_hit[c] = 1'b0;
    end
  endfunction

  function automatic void reset_model();
    int i;
    thr_q       = THRESH_RESET;
    hold_len_q  = HOLDOFF_RESET;
    for (i = 0; i < QUIET_WINDOW; i++) quiet_ring[i] = 1'b0;
    quiet_total = 0;
    ring_ptr    = 0;
    loud_q      = 1'b1;
    armed_q     = 1'b0;
    holdoff_ctr = {1'b0, HOLDOFF_RESET};
    onset_age   = '0;
    clear_arrivals();
    sample_no   = '0;
  endfunction

  // One sample through the detector; returns 1 and fills ping when a ping comes out.
  function automatic bit step_detector(input mag_set_t mag, output ping_t ping);
    bit quiet;
    bit was_loud;
    bit all_hit;
    int c;
    quiet = 1'b1;
    ping  = '0;
    sample_no++;

    // Equal to the threshold is not quiet.
    for (c = 0; c < CHANNELS; c++)
      if (mag[c] >= thr_q) quiet = 1'b0;

    // Sliding quiet window: the slot we overwrite leaves the count.
    ring_ptr    = (ring_ptr + 1) % QUIET_WINDOW;
    quiet_total = quiet_total - quiet_ring[ring_ptr] + quiet;
    quiet_ring[ring_ptr] = quiet;

    was_loud = loud_q;
    loud_q   = quiet_total < QUIET_WINDOW;
    if (!loud_q) begin
      onset_age = '0;
      armed_q   = 1'b0;
      clear_arrivals();
    end

    // A shortened holdoff simply counts as run out.
    if (holdoff_ctr <= hold_len_q) holdoff_ctr++;
    if (!was_loud && loud_q) armed_q = 1'b1;
    if (!(armed_q && loud_q && holdoff_ctr > hold_len_q)) return 1'b0;

    // Latch first strict crossing per channel.
    all_hit = 1'b1;
    for (c = 0; c < CHANNELS; c++) begin
      if (!arr_hit[c]) begin
        if (mag[c] > thr_q) begin
          arr_hit[c] = 1'b1;
          arr_off[c] = onset_age;
        end else begin
          all_hit = 1'b0;
        end
      end
    end
    if (onset_age != OFFSET_MAX) onset_age++;  // saturating onset offset
    if (!all_hit) return 1'b0;

    ping.sample_idx = sample_no;
    for (c = 0; c < CH_PORTS; c++)
      ping.arrival[c] = (c < CHANNELS) ? arr_off[c] : '0;
    holdoff_ctr = '0;
    onset_age   = '0;
    clear_arrivals();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got_v, want_v);
    mismatches++;
  endtask

  // Scoreboard: results are checked before the same edge's input is predicted, since a
  // result always belongs to an earlier input.
  always @(posedge clk) begin : scoreboard
    ping_t got;
    ping_t want;
    ping_t calc;
    bit    fired;
    int    c;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pings_due.size() == 0) begin
          flag_mismatch("ping with none pending, ping_sample_index", got.sample_idx, '0);
        end else begin
          want = pings_due.pop_front();
          if (got.sample_idx !== want.sample_idx)
            flag_mismatch("ping_sample_index", got.sample_idx, want.sample_idx);
          for (c = 0; c < CH_PORTS; c++)
            if (got.arrival[c] !== want.arrival[c])
              flag_mismatch($sformatf("arrival_ch%0d", c), got.arrival[c], want.arrival[c]);
        end
      end
      if (s_tvalid && s_tready) begin
        fired = step_detector(s_tdata, calc);
        case (item_check)
          WANT_PING:  pings_due.push_back(item_ping);
          WANT_MODEL: if (fired) pings_due.push_back(calc);
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, steady ready otherwise.
  initial begin : ready_driver
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(5, 0) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(7, 1)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // One sample transfer, with an optional gap in front of it.
  task automatic send_sample(input mag_set_t mag, input row_check_t check, input ping_t typed);
    if (idle_on && $urandom_range(5, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= mag;
    item_check <= check;
    item_ping  <= typed;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Register write; drops the enable again and waits with it low before returning.
  task automatic write_reg(input reg_index_t sel, input logic [MAG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_THRESHOLD: thr_q = value;
      REG_HOLDOFF:   hold_len_q = value[HOLDOFF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop sending, wait for every pending ping, then let in-flight samples settle.
  // The first edge lets the scoreboard book the last accepted sample.
  task automatic drain_pings();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic plan_row_t write_row(input reg_index_t sel, input logic [MAG_W-1:0] value);
    plan_row_t r;
    r.kind    = ROW_WRITE;
    r.reg_sel = sel;
    r.value   = value;
    r.mag     = '0;
    r.repeats = 0;
    r.check   = WANT_NONE;
    r.ping    = '0;
    return r;
  endfunction

  function automatic plan_row_t sample_row(input mag_set_t mag, input int unsigned repeats,
                                           input row_check_t check, input ping_t ping);
    plan_row_t r;
    r.kind    = ROW_SAMPLE;
    r.reg_sel = REG_THRESHOLD;
    r.value   = '0;
    r.mag     = mag;
    r.repeats = repeats;
    r.check   = check;
    r.ping    = ping;
    return r;
  endfunction

  // Every channel strictly below threshold (threshold must be nonzero).
  function automatic mag_set_t quiet_set();
    mag_set_t m;
    int c;
    for (c = 0; c < CH_PORTS; c++) m[c] = $urandom_range(thr_q - 1, 0);
    return m;
  endfunction

  // Signal stretch: mostly per-channel arrivals at hit_pct, with some noise, some fully
  // quiet samples and some magnitudes sitting right on the threshold.
  function automatic mag_set_t loud_set(input int unsigned hit_pct);
    mag_set_t    m;
    int          c;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      for (c = 0; c < CH_PORTS; c++) m[c] = $urandom;
    end else if (pick < 22) begin
      m = quiet_set();
    end else begin
      for (c = 0; c < CH_PORTS; c++) begin
        if ($urandom_range(99, 0) < hit_pct)
          m[c] = $urandom_range(32'hFFFF_FFFF, thr_q + 1);
        else if ($urandom_range(9, 0) == 0)
          m[c] = thr_q;
        else
          m[c] = $urandom_range(thr_q - 1, 0);
      end
    end
    return m;
  endfunction

  initial begin : stimulus
    plan_row_t   plan[$];
    ping_t       first_ping;
    int unsigned phase;
    int unsigned fill;
    int unsigned burst;
    int unsigned hit_pct;

    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan. The first ping after reset is plain: 256 quiet samples fill the
    // window, the next loud one arms, and with the holdoff already run out every channel
    // arrives at offset zero.
    first_ping = '0;
    first_ping.sample_idx = 257;
    plan.push_back(sample_row('0, QUIET_WINDOW, WANT_NONE, '0));
    plan.push_back(sample_row('1, 1, WANT_PING, first_ping));
    // Zero holdoff: still armed and loud, so detection goes on right away.
    plan.push_back(write_row(REG_HOLDOFF, '0));
    plan.push_back(write_row(REG_THRESHOLD, 1000));
    // Exactly at threshold: neither quiet nor an arrival.
    plan.push_back(sample_row({4{32'd1000}}, 3, WANT_NONE, '0));
    // Channels arrive one by one, staggered offsets.
    plan.push_back(sample_row({32'd1000, 32'd999, 32'd0, 32'd1001}, 1, WANT_MODEL, '0));
    plan.push_back(sample_row({32'd0, 32'd0, 32'h5555_5555, 32'd0}, 1, WANT_MODEL, '0));
    plan.push_back(sample_row({32'd0, 32'hAAAA_AAAA, 32'd0, 32'd0}, 1, WANT_MODEL, '0));
    plan.push_back(sample_row({32'd1001, 32'd0, 32'd0, 32'd0}, 1, WANT_MODEL, '0));
    // Zero threshold: zero magnitudes never arrive, one does.
    plan.push_back(write_row(REG_THRESHOLD, '0));
    plan.push_back(sample_row('0, 2, WANT_NONE, '0));
    plan.push_back(sample_row({4{32'd1}}, 1, WANT_MODEL, '0));
    // Full-scale threshold: nothing can be strictly above it.
    plan.push_back(write_row(REG_THRESHOLD, '1));
    plan.push_back(sample_row('1, 2, WANT_NONE, '0));
    plan.push_back(sample_row({4{32'hFFFF_FFFE}}, 1, WANT_NONE, '0));
    // Longest holdoff blocks detection; shortening it afterwards frees it at once.
    plan.push_back(write_row(REG_THRESHOLD, THRESH_RESET));
    plan.push_back(write_row(REG_HOLDOFF, 32'(OFFSET_MAX)));
    plan.push_back(sample_row('1, 4, WANT_NONE, '0));
    plan.push_back(write_row(REG_HOLDOFF, 2));
    plan.push_back(sample_row({32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd3001}, 1,
                              WANT_MODEL, '0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_pings();
        write_reg(plan[i].reg_sel, plan[i].value);
      end else begin
        repeat (plan[i].repeats) send_sample(plan[i].mag, plan[i].check, plan[i].ping);
      end
    end

    // Random phases: new settings, a quiet stretch (sometimes cut short, so the window
    // never turns quiet), then a signal stretch that keeps pinging while loud.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      drain_pings();
      idle_on = (phase != RAND_PHASES - 1) && ($urandom_range(3, 0) != 0);
      if ($urandom_range(1, 0) == 0)
        write_reg(REG_THRESHOLD, $urandom_range(5000, 1));
      else
        write_reg(REG_THRESHOLD, $urandom_range(32'hFFFF_FFFE, 1));
      if (phase == PRESSURE_PHASE)
        write_reg(REG_HOLDOFF, '0);
      else if ($urandom_range(2, 0) == 0)
        write_reg(REG_HOLDOFF, $urandom_range(60, 8));
      else
        write_reg(REG_HOLDOFF, $urandom_range(4, 0));

      if (phase != PRESSURE_PHASE && $urandom_range(3, 0) == 0)
        fill = $urandom_range(QUIET_WINDOW - 1, 200);
      else
        fill = $urandom_range(QUIET_WINDOW + 6, QUIET_WINDOW);
      repeat (fill) send_sample(quiet_set(), WANT_MODEL, '0);

      // Pressure phase: zero holdoff and a high hit rate make pings frequent while the receiver
      // holds off, so the block backs up and stalls its input.
      if (phase == PRESSURE_PHASE) begin
        hit_pct  = 95;
        hold_req = 1'b1;
      end else begin
        hit_pct = $urandom_range(90, 25);
      end
      burst = $urandom_range(100, 40);
      repeat (burst) send_sample(loud_set(hit_pct), WANT_MODEL, '0);
    end

    drain_pings();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
